FILE: design/ffp_pkg.sv
// ----------------------------------------------------------------------------
// ffp_pkg
// Shared types and constants of the FIX frame parser.
// ----------------------------------------------------------------------------
package ffp_pkg;

  localparam logic [7:0]  SOH_BYTE     = 8'h01;
  localparam logic [7:0]  EQ_BYTE      = 8'h3d;
  localparam logic [7:0]  EIGHT_BYTE   = 8'h38;
  localparam logic [12:0] OFFSET_LIMIT = 13'h1fff;
  localparam logic [19:0] TAG_LIMIT    = 20'hfffff;
  // byte sum of "8=FIX" mod 256
  localparam logic [7:0]  START_SUM    = 8'd92;
  localparam int          FIFO_DEPTH   = 4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MISSING   = 3'd1;
  localparam logic [2:0] ST_CHECKSUM  = 3'd2;
  localparam logic [2:0] ST_BAD_LEN   = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;

  localparam logic CFG_CHECK_EN = 1'b0;
  localparam logic CFG_MAX_LEN  = 1'b1;

  typedef enum logic [2:0] {
    MODE_HUNT, MODE_TAG_START, MODE_TAG, MODE_VALUE, MODE_SKIP
  } mode_t;

  typedef struct packed {
    logic [19:0] field_tag;
    logic [31:0] value_number;
    logic        value_numeric;
    logic [12:0] value_length;
    logic [12:0] value_offset;
    logic        frame_end;
    logic [2:0]  frame_status;
    logic [7:0]  computed_sum;
  } result_t;

  // Characters of the frame start text "8=FIX"
  function automatic logic [7:0] start_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h38;
      3'd1:    c = 8'h3d;
      3'd2:    c = 8'h46;
      3'd3:    c = 8'h49;
      3'd4:    c = 8'h58;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: design/ffp_parser.sv
// ----------------------------------------------------------------------------
// ffp_parser
// Front end: takes one byte per cycle, tracks framing and emits field records.
// ----------------------------------------------------------------------------
module ffp_parser import ffp_pkg::*; #(
  parameter int MAX_BODY   = 4096,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [7:0]  data_byte,
  input  logic        check_en,
  input  logic [12:0] max_len,
  output logic        res_valid,
  output result_t     res
);

  localparam int BODY_W = $clog2(MAX_BODY + 1);
  localparam int CMP_W  = VALUE_BITS + 18;
  localparam int ACC_W  = VALUE_BITS + 4;

  mode_t                  mode, mode_next;
  logic [2:0]             prefix_cnt, prefix_cnt_next;
  logic [19:0]            tag_acc, tag_acc_next;
  logic [VALUE_BITS-1:0]  val_acc, val_acc_next;
  logic                   val_digits, val_digits_next;
  logic [12:0]            val_cnt, val_cnt_next;
  logic [12:0]            offset, offset_next;
  logic [BODY_W-1:0]      body_rem, body_rem_next;
  logic [7:0]             run_sum, run_sum_next;
  logic [7:0]             fld_sum, fld_sum_next;
  logic [4:0]             req_seen, req_seen_next;
  logic                   in_trailer, in_trailer_next;
  logic                   len_known, len_known_next;

  // Compute next state and the emitted record for the current byte
  always_comb begin
    logic                  digit;
    logic [3:0]            dval;
    logic [23:0]           tag_x10;
    logic [19:0]           tag_push;
    logic [ACC_W-1:0]      val_x10;
    logic [VALUE_BITS-1:0] val_push;
    logic [VALUE_BITS-1:0] vmax;
    logic [2:0]            pc;
    logic                  abort;
    logic [BODY_W-1:0]     rem_n;
    logic                  numeric;
    logic                  nonempty;
    logic [VALUE_BITS-1:0] num;
    logic [CMP_W-1:0]      lim;
    logic                  fend;
    logic [2:0]            fstat;

    mode_next       = mode;
    prefix_cnt_next = prefix_cnt;
    tag_acc_next    = tag_acc;
    val_acc_next    = val_acc;
    val_digits_next = val_digits;
    val_cnt_next    = val_cnt;
    offset_next     = offset;
    body_rem_next   = body_rem;
    run_sum_next    = run_sum;
    fld_sum_next    = fld_sum;
    req_seen_next   = req_seen;
    in_trailer_next = in_trailer;
    len_known_next  = len_known;
    res_valid       = 1'b0;
    res             = '0;

    digit    = (data_byte >= 8'h30) && (data_byte <= 8'h39);
    dval     = 4'(data_byte - 8'h30);
    tag_x10  = {1'b0, tag_acc, 3'b0} + {3'b0, tag_acc, 1'b0} + 24'(dval);
    tag_push = (tag_x10 > 24'(TAG_LIMIT)) ? TAG_LIMIT : tag_x10[19:0];
    vmax     = '1;
    val_x10  = {1'b0, val_acc, 3'b0} + {3'b0, val_acc, 1'b0} + ACC_W'(dval);
    val_push = (val_x10 > ACC_W'(vmax)) ? vmax : val_x10[VALUE_BITS-1:0];
    pc       = prefix_cnt;
    abort    = 1'b0;
    rem_n    = body_rem;
    numeric  = val_digits && (val_cnt != 13'd0);
    nonempty = (val_cnt != 13'd0);
    num      = numeric ? val_acc : '0;
    lim      = (CMP_W'(max_len) < CMP_W'(MAX_BODY)) ? CMP_W'(max_len) : CMP_W'(MAX_BODY);
    fend     = 1'b0;
    fstat    = ST_OK;

    if (in_valid) begin
      if (mode == MODE_HUNT) begin
        // hunt for the start text
        if (pc < 3'd5 && data_byte == start_char(pc)) begin
          pc = pc + 3'd1;
        end else begin
          pc = (data_byte == EIGHT_BYTE) ? 3'd1 : 3'd0;
        end
        prefix_cnt_next = pc;
        if (pc == 3'd5) begin
          mode_next       = MODE_VALUE;
          tag_acc_next    = 20'd8;
          val_acc_next    = '0;
          val_digits_next = 1'b0;
          val_cnt_next    = 13'd3;
          offset_next     = 13'd5;
          body_rem_next   = '0;
          run_sum_next    = 8'd0;
          req_seen_next   = 5'd0;
          in_trailer_next = 1'b0;
          len_known_next  = 1'b0;
          fld_sum_next    = START_SUM;
        end
      end else if (offset == OFFSET_LIMIT) begin
        // frame too long
        res_valid          = 1'b1;
        res.frame_end      = 1'b1;
        res.frame_status   = ST_TOO_LONG;
        res.computed_sum   = run_sum;
        mode_next          = MODE_HUNT;
        prefix_cnt_next    = 3'd0;
      end else begin
        offset_next = offset + 13'd1;
        // count down the body
        if (len_known && !in_trailer) begin
          if (body_rem != '0) rem_n = body_rem - BODY_W'(1);
          body_rem_next = rem_n;
          if (rem_n == '0) begin
            if (data_byte != SOH_BYTE) begin
              abort            = 1'b1;
              res_valid        = 1'b1;
              res.frame_end    = 1'b1;
              res.frame_status = ST_BAD_LEN;
              res.computed_sum = run_sum;
              mode_next        = MODE_HUNT;
              prefix_cnt_next  = 3'd0;
            end else begin
              in_trailer_next = 1'b1;
            end
          end
        end

        if (!abort) begin
          if (mode == MODE_VALUE && data_byte == SOH_BYTE) begin
            // complete a field
            if (tag_acc == 20'd10) begin
              fend = 1'b1;
              if (len_known && !in_trailer) fstat = ST_BAD_LEN;
              else if (req_seen != 5'h1f) fstat = ST_MISSING;
              else if (check_en && (!numeric || num != VALUE_BITS'(run_sum)))
                fstat = ST_CHECKSUM;
            end else if (in_trailer) begin
              fend  = 1'b1;
              fstat = ST_BAD_LEN;
            end else if (tag_acc == 20'd8) begin
              req_seen_next[0] = nonempty;
            end else if (tag_acc == 20'd35) begin
              req_seen_next[2] = nonempty;
            end else if (tag_acc == 20'd49) begin
              req_seen_next[3] = nonempty;
            end else if (tag_acc == 20'd56) begin
              req_seen_next[4] = nonempty;
            end else if (tag_acc == 20'd9 && !len_known) begin
              if (!numeric) begin
                fend  = 1'b1;
                fstat = ST_BAD_LEN;
              end else if (CMP_W'(num) > lim) begin
                fend  = 1'b1;
                fstat = ST_TOO_LONG;
              end else begin
                len_known_next   = 1'b1;
                body_rem_next    = BODY_W'(num);
                req_seen_next[1] = (num != '0);
                if (num == '0) in_trailer_next = 1'b1;
              end
            end
            res_valid         = 1'b1;
            res.field_tag     = tag_acc;
            res.value_number  = 32'(num);
            res.value_numeric = numeric;
            res.value_length  = val_cnt;
            res.value_offset  = offset - val_cnt;
            res.frame_end     = fend;
            res.frame_status  = fstat;
            res.computed_sum  = run_sum;
            run_sum_next      = run_sum + fld_sum + 8'd1;
            fld_sum_next      = 8'd0;
            mode_next         = MODE_TAG_START;
            if (fend) begin
              mode_next       = MODE_HUNT;
              prefix_cnt_next = 3'd0;
            end
          end else if (data_byte == SOH_BYTE) begin
            // drop a field without a tag
            run_sum_next = run_sum + fld_sum + 8'd1;
            fld_sum_next = 8'd0;
            mode_next    = MODE_TAG_START;
          end else begin
            fld_sum_next = fld_sum + data_byte;
            case (mode)
              MODE_TAG_START, MODE_TAG: begin
                if (digit) begin
                  tag_acc_next = (mode == MODE_TAG_START) ? 20'(dval) : tag_push;
                  mode_next    = MODE_TAG;
                end else if (data_byte == EQ_BYTE && mode == MODE_TAG) begin
                  mode_next       = MODE_VALUE;
                  val_acc_next    = '0;
                  val_digits_next = 1'b1;
                  val_cnt_next    = 13'd0;
                end else begin
                  mode_next = MODE_SKIP;
                end
              end
              MODE_VALUE: begin
                if (val_cnt < OFFSET_LIMIT) val_cnt_next = val_cnt + 13'd1;
                if (digit && val_digits) val_acc_next = val_push;
                else val_digits_next = 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_HUNT;
      prefix_cnt <= 3'd0;
      tag_acc    <= 20'd0;
      val_acc    <= '0;
      val_digits <= 1'b1;
      val_cnt    <= 13'd0;
      offset     <= 13'd0;
      body_rem   <= '0;
      run_sum    <= 8'd0;
      fld_sum    <= 8'd0;
      req_seen   <= 5'd0;
      in_trailer <= 1'b0;
      len_known  <= 1'b0;
    end else begin
      mode       <= mode_next;
      prefix_cnt <= prefix_cnt_next;
      tag_acc    <= tag_acc_next;
      val_acc    <= val_acc_next;
      val_digits <= val_digits_next;
      val_cnt    <= val_cnt_next;
      offset     <= offset_next;
      body_rem   <= body_rem_next;
      run_sum    <= run_sum_next;
      fld_sum    <= fld_sum_next;
      req_seen   <= req_seen_next;
      in_trailer <= in_trailer_next;
      len_known  <= len_known_next;
    end
  end

endmodule

FILE: design/ffp_fifo.sv
// ----------------------------------------------------------------------------
// ffp_fifo
// Result queue between the parser and the consumer.
// ----------------------------------------------------------------------------
module ffp_fifo import ffp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  result_t wr_data,
  input  logic    rd_en,
  output result_t rd_data,
  output logic    full,
  output logic    empty
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  result_t           mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == CNT_W'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Store transactions
  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_rd) rd_ptr <= rd_ptr + PTR_W'(1);
      if (do_wr && !do_rd) count <= count + CNT_W'(1);
      else if (do_rd && !do_wr) count <= count - CNT_W'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH)) else $error("fifo count overflow");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> count == $past(count) + CNT_W'(1))
    else $error("fifo push lost");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (do_rd && !do_wr) |=> count == $past(count) - CNT_W'(1))
    else $error("fifo pop lost");

endmodule

FILE: design/fix_frame_parser.sv
// ----------------------------------------------------------------------------
// fix_frame_parser
// FIX tag=value frame parser; status at the checksum field or an early end.
// ----------------------------------------------------------------------------
// Takes one byte per clock while full is low: the parser front end handles
// each byte combinationally and writes at most one field record into a
// four-entry result queue, so full rises only when the consumer stops popping
// and the queue fills. There is no clearing pass after reset.
module fix_frame_parser import ffp_pkg::*; #(
  parameter int MAX_BODY   = 4096,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        pop,
  output logic        empty,
  output logic [19:0] field_tag,
  output logic [31:0] value_number,
  output logic        value_numeric,
  output logic [12:0] value_length,
  output logic [12:0] value_offset,
  output logic        frame_end,
  output logic [2:0]  frame_status,
  output logic [7:0]  computed_sum,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  logic        check_en;
  logic [12:0] max_len;
  logic        res_valid;
  result_t     res;
  result_t     head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      check_en <= 1'b1;
      max_len  <= 13'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHECK_EN: check_en <= cfg_data[0];
        CFG_MAX_LEN:  max_len  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ffp_parser #(.MAX_BODY(MAX_BODY), .VALUE_BITS(VALUE_BITS)) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push && !full),
    .data_byte (data_byte),
    .check_en  (check_en),
    .max_len   (max_len),
    .res_valid (res_valid),
    .res       (res)
  );

  ffp_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_en   (pop),
    .rd_data (head),
    .full    (full),
    .empty   (empty)
  );

  assign field_tag     = head.field_tag;
  assign value_number  = head.value_number;
  assign value_numeric = head.value_numeric;
  assign value_length  = head.value_length;
  assign value_offset  = head.value_offset;
  assign frame_end     = head.frame_end;
  assign frame_status  = head.frame_status;
  assign computed_sum  = head.computed_sum;

endmodule
